### hdl/vqpa_pkg.sv
package vqpa_pkg;

    // Stream widths
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 104;
    localparam int KIND_W    = 2;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RING_FULL  = 2'd1;
    localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_DESC   = 2'd0;
    localparam logic [1:0] KIND_AVAIL  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Descriptor flags
    localparam logic [1:0] FLAGS_NONE  = 2'd0;
    localparam logic [1:0] FLAGS_NEXT  = 2'd1;
    localparam logic [1:0] FLAGS_WRITE = 2'd2;

    // Input command codes
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_FREE   = 1'b1;

    // Last value of the available index before it wraps
    localparam logic [15:0] AVAIL_MAX = 16'hFFFF;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_CMD    = 6'b000100,
        ST_RESP   = 6'b001000,
        ST_AVAIL  = 6'b010000,
        ST_STATUS = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_CMD,
        SEL_RESP,
        SEL_AVAIL,
        SEL_FREE,
        SEL_FULL
    } out_sel_t;

    typedef struct packed {
        logic     latch;
        logic     advance;
        logic     alloc;
        logic     drop;
        out_sel_t load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_free_cmd;
        logic ring_full;
        logic cur_free;
    } dp_stat_t;

    typedef struct packed {
        logic        command;
        logic [31:0] cmd_address;
        logic [31:0] cmd_length;
        logic [31:0] resp_address;
        logic [31:0] resp_length;
        logic [5:0]  pair_head;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [31:0] address;
        logic [31:0] length;
        logic [1:0]  flags;
        logic [5:0]  next_index;
        logic [5:0]  head_index;
        logic [15:0] avail_count;
        logic        notify;
        logic        last;
    } out_item_t;

endpackage

### hdl/vqpa_ctrl.sv
module vqpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  vqpa_pkg::dp_stat_t  stat,
    output vqpa_pkg::ctrl_cmd_t cmd
);
    import vqpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence search, allocation and the emitted items
    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.latch   = 1'b0;
        cmd.advance = 1'b0;
        cmd.alloc   = 1'b0;
        cmd.drop    = 1'b0;
        cmd.load    = SEL_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (stat.is_free_cmd)
                begin
                    cmd.drop   = 1'b1;
                    cmd.load   = SEL_FREE;
                    state_next = ST_STATUS;
                end
                else if (stat.ring_full)
                begin
                    cmd.load   = SEL_FULL;
                    state_next = ST_STATUS;
                end
                else if (stat.cur_free)
                begin
                    cmd.alloc  = 1'b1;
                    cmd.load   = SEL_CMD;
                    state_next = ST_CMD;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_CMD:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.load   = SEL_RESP;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.load   = SEL_AVAIL;
                    state_next = ST_AVAIL;
                end
            end
            ST_AVAIL, ST_STATUS:
            begin
                // Take the next item as the final result leaves
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/vqpa_datapath.sv
module vqpa_datapath #(
    parameter int RING_DESCRIPTORS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  vqpa_pkg::ctrl_cmd_t                   cmd,
    output vqpa_pkg::dp_stat_t                    stat,
    input  logic [vqpa_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                  s_tuser,
    output logic [vqpa_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [vqpa_pkg::KIND_W-1:0]           m_tuser,
    output logic                                  m_tlast
);
    import vqpa_pkg::*;

    localparam int PAIRS = RING_DESCRIPTORS / 2;
    localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int CW    = $clog2(PAIRS + 1);
    localparam int RW    = $clog2(RING_DESCRIPTORS);
    localparam int HW    = (PW + 1 > 6) ? PW + 1 : 6;
    localparam int SW    = (RW > 6) ? RW : 6;
    localparam int FW    = (PW > 5) ? PW : 5;

    in_item_t        in_reg;
    logic [PAIRS-1:0] in_use_reg;
    logic [CW-1:0]   free_cnt_reg;
    logic [PW-1:0]   cur_reg;
    logic [PW-1:0]   pair_reg;
    logic [5:0]      slot_reg;
    logic [15:0]     avail_reg;
    logic [RW-1:0]   ring_pos_reg;
    out_item_t       out_reg;
    out_item_t       out_next;

    logic [FW-1:0]   free_wide;
    logic            free_in_range;
    logic [PW-1:0]   free_idx;
    logic [PW-1:0]   rd_idx;
    logic            rd_bit;
    logic            pair_ok;
    logic [PW-1:0]   cur_inc;
    logic [RW-1:0]   ring_pos_inc;
    logic [SW-1:0]   ring_pos_wide;
    logic [15:0]     avail_inc;

    // Descriptor index 2p or 2p+1, kept to six bits
    function automatic logic [5:0] desc_index(input logic [PW-1:0] p, input logic odd);
        logic [HW-1:0] w;
        w = (HW'(p) << 1) | HW'(odd);
        return w[5:0];
    endfunction

    // Pair named by a free, checked against the ring size
    assign free_wide     = FW'(in_reg.pair_head[5:1]);
    assign free_in_range = {1'b0, free_wide} < (FW + 1)'(PAIRS);
    assign free_idx      = free_wide[PW-1:0];

    // One read port on the in-use marks
    assign rd_idx  = (in_reg.command == CMD_FREE) ? free_idx : cur_reg;
    assign rd_bit  = in_use_reg[rd_idx];
    assign pair_ok = free_in_range && rd_bit;

    assign stat.is_free_cmd = (in_reg.command == CMD_FREE);
    assign stat.ring_full   = (free_cnt_reg == '0);
    assign stat.cur_free    = !rd_bit;

    // Circular increments
    assign cur_inc      = (cur_reg == PW'(PAIRS - 1)) ? '0 : cur_reg + 1'b1;
    assign ring_pos_inc = ((avail_reg == AVAIL_MAX) ||
                           (ring_pos_reg == RW'(RING_DESCRIPTORS - 1))) ?
                          '0 : ring_pos_reg + 1'b1;
    assign ring_pos_wide = SW'(ring_pos_reg);
    assign avail_inc     = avail_reg + 16'd1;

    // Latch the accepted item, the allocated pair and slot, and the next result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_reg.command      <= s_tuser;
            in_reg.cmd_address  <= s_tdata[31:0];
            in_reg.cmd_length   <= s_tdata[63:32];
            in_reg.resp_address <= s_tdata[95:64];
            in_reg.resp_length  <= s_tdata[127:96];
            in_reg.pair_head    <= s_tdata[133:128];
        end
        if (cmd.alloc)
        begin
            pair_reg <= cur_reg;
            slot_reg <= ring_pos_wide[5:0];
        end
        out_reg <= out_next;
    end

    // Update allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg   <= '0;
            free_cnt_reg <= CW'(PAIRS);
            cur_reg      <= '0;
            avail_reg    <= '0;
            ring_pos_reg <= '0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                in_use_reg[cur_reg] <= 1'b1;
                free_cnt_reg        <= free_cnt_reg - 1'b1;
                cur_reg             <= cur_inc;
                avail_reg           <= avail_inc;
                ring_pos_reg        <= ring_pos_inc;
            end
            else if (cmd.advance)
            begin
                cur_reg <= cur_inc;
            end
            if (cmd.drop && pair_ok)
            begin
                in_use_reg[free_idx] <= 1'b0;
                free_cnt_reg         <= free_cnt_reg + 1'b1;
            end
        end
    end

    // Build the next result item
    always_comb
    begin
        out_next = out_reg;
        unique case (cmd.load)
            SEL_NONE:
            begin
                out_next = out_reg;
            end
            SEL_CMD:
            begin
                out_next = '{status: STATUS_OK, kind: KIND_DESC,
                             slot: desc_index(cur_reg, 1'b0),
                             address: in_reg.cmd_address, length: in_reg.cmd_length,
                             flags: FLAGS_NEXT, next_index: desc_index(cur_reg, 1'b1),
                             head_index: 6'd0, avail_count: avail_inc,
                             notify: 1'b0, last: 1'b0};
            end
            SEL_RESP:
            begin
                out_next = '{status: STATUS_OK, kind: KIND_DESC,
                             slot: desc_index(pair_reg, 1'b1),
                             address: in_reg.resp_address, length: in_reg.resp_length,
                             flags: FLAGS_WRITE, next_index: 6'd0,
                             head_index: 6'd0, avail_count: avail_reg,
                             notify: 1'b0, last: 1'b0};
            end
            SEL_AVAIL:
            begin
                out_next = '{status: STATUS_OK, kind: KIND_AVAIL, slot: slot_reg,
                             address: 32'd0, length: 32'd0,
                             flags: FLAGS_NONE, next_index: 6'd0,
                             head_index: desc_index(pair_reg, 1'b0),
                             avail_count: avail_reg, notify: 1'b1, last: 1'b1};
            end
            SEL_FREE:
            begin
                out_next = '{status: pair_ok ? STATUS_OK : STATUS_NOT_IN_USE,
                             kind: KIND_STATUS, slot: 6'd0,
                             address: 32'd0, length: 32'd0,
                             flags: FLAGS_NONE, next_index: 6'd0, head_index: 6'd0,
                             avail_count: avail_reg, notify: 1'b0, last: 1'b1};
            end
            SEL_FULL:
            begin
                out_next = '{status: STATUS_RING_FULL, kind: KIND_STATUS, slot: 6'd0,
                             address: 32'd0, length: 32'd0,
                             flags: FLAGS_NONE, next_index: 6'd0, head_index: 6'd0,
                             avail_count: avail_reg, notify: 1'b0, last: 1'b1};
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    // Pack the result onto the master side
    assign m_tdata = {1'b0, out_reg.notify, out_reg.avail_count, out_reg.head_index,
                      out_reg.next_index, out_reg.flags, out_reg.length,
                      out_reg.address, out_reg.slot, out_reg.status};
    assign m_tuser = out_reg.kind;
    assign m_tlast = out_reg.last;

endmodule

### hdl/virtqueue_pair_alloc_submit_top.sv
// Pair allocator and submitter for the control ring of a split virtqueue.
// Descriptors 2p and 2p+1 form pair p; a submit item takes the next free pair
// searching circularly from just after the last allocation and yields three
// result items (command descriptor linked to its partner, device-writable
// response descriptor, available-ring entry with notify), while a free item
// or a submit on a full ring yields a single status item. The search tests
// one in-use mark per cycle and skips at most pairs - 1 in-use pairs before
// it finds a free one. One item is worked on at a time, and the next one is
// accepted on the edge at which the final result item is taken.
module virtqueue_pair_alloc_submit_top #(
    parameter int RING_DESCRIPTORS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // cmd_address[31:0], cmd_length[63:32], resp_address[95:64],
    // resp_length[127:96], pair_head[133:128], zero fill[135:134]
    input  logic [vqpa_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // status[1:0], slot[7:2], address[39:8], length[71:40], flags[73:72],
    // next_index[79:74], head_index[85:80], avail_count[101:86],
    // notify[102], zero fill[103]
    output logic [vqpa_pkg::M_TDATA_W-1:0]     m_tdata,
    // kind
    output logic [vqpa_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready
);
    import vqpa_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    vqpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    vqpa_datapath #(
        .RING_DESCRIPTORS (RING_DESCRIPTORS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ctrl_cmd),
        .stat    (dp_stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // An item is taken alongside a result only when that result is the final one
    a_accept_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("input taken while a non-final result is pending");

    // The descriptors of a submit are followed by a further result
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("result sequence broken after a descriptor");

    // The available-ring entry closes a submit
    a_avail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_AVAIL)) |-> (m_tlast && m_tdata[102]))
        else $error("available entry without last or notify");

    // A descriptor write is never the final result
    a_desc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_DESC)) |-> !m_tlast)
        else $error("descriptor write marked last");

endmodule
